// ===== hdl/pflr_pkg.sv =====
`default_nettype none

package pflr_pkg;

  // Default screen geometry
  localparam int DEF_WIDTH_PX  = 128;
  localparam int DEF_HEIGHT_PX = 64;

  // Page layout: eight rows share one byte
  localparam int PAGE_SHIFT       = 3;
  localparam int BIT_IN_PAGE_MASK = 7;

  // Field widths
  localparam int FUNC_W  = 2;
  localparam int COORD_W = 12;
  localparam int POS_W   = COORD_W + 1;  // walk positions and endpoint differences
  localparam int ERR_W   = POS_W + 1;    // Bresenham error term
  localparam int INDEX_W = 10;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 8;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LINE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // One pixel of the walk, screen coordinates
  typedef struct packed {
    logic                    valid;
    logic                    last;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
  } pixel_t;

endpackage

`default_nettype wire

// ===== hdl/pflr_stepper.sv =====
`default_nettype none

// Bresenham walker: setup states SP_DIFF, SP_ORDER and SP_PREP, then one pixel per cycle.
module pflr_stepper (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  input  wire logic signed [pflr_pkg::COORD_W-1:0]   ax_in,
  input  wire logic signed [pflr_pkg::COORD_W-1:0]   ay_in,
  input  wire logic signed [pflr_pkg::COORD_W-1:0]   bx_in,
  input  wire logic signed [pflr_pkg::COORD_W-1:0]   by_in,
  output pflr_pkg::pixel_t                           pix
);

  localparam int POS_W   = pflr_pkg::POS_W;
  localparam int ERR_W   = pflr_pkg::ERR_W;
  localparam int COORD_W = pflr_pkg::COORD_W;

  typedef enum logic [4:0] {
    SP_IDLE  = 5'b00001,
    SP_DIFF  = 5'b00010,
    SP_ORDER = 5'b00100,
    SP_PREP  = 5'b01000,
    SP_WALK  = 5'b10000
  } step_state_t;

  step_state_t state;

  logic signed [POS_W-1:0] ax, ay, bx, by;
  logic signed [POS_W-1:0] ddx, ddy;
  logic signed [POS_W-1:0] u, v, u_end, v_end;
  logic                    steep;
  logic        [POS_W-1:0] dx, dy;
  logic signed [ERR_W-1:0] err;
  logic                    up;
  logic      [COORD_W-1:0] cnt;

  // Ordering: swap axes for steep lines, then put the lower major coordinate first
  logic        [POS_W-1:0] adx, ady;
  logic                    steep_c;
  logic signed [POS_W-1:0] su0, sv0, su1, sv1;

  always_comb begin
    adx     = ddx[POS_W-1] ? POS_W'(-ddx) : POS_W'(ddx);
    ady     = ddy[POS_W-1] ? POS_W'(-ddy) : POS_W'(ddy);
    steep_c = ady > adx;
    su0     = steep_c ? ay : ax;
    sv0     = steep_c ? ax : ay;
    su1     = steep_c ? by : bx;
    sv1     = steep_c ? bx : by;
  end

  // Setup of step sizes
  logic signed [POS_W-1:0] dx_c, dv_c;

  always_comb begin
    dx_c = u_end - u;
    dv_c = v_end - v;
  end

  // One error update per pixel
  logic signed [ERR_W-1:0] err_dec;

  always_comb begin
    err_dec = err - $signed({1'b0, dy});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SP_IDLE;
    end else begin
      unique case (state)
        SP_IDLE:  if (start) state <= SP_DIFF;
        SP_DIFF:  state <= SP_ORDER;
        SP_ORDER: state <= SP_PREP;
        SP_PREP:  state <= SP_WALK;
        SP_WALK:  if (cnt == '0) state <= SP_IDLE;
        default:  state <= SP_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      SP_IDLE: begin
        ax <= POS_W'(ax_in);
        ay <= POS_W'(ay_in);
        bx <= POS_W'(bx_in);
        by <= POS_W'(by_in);
      end
      SP_DIFF: begin
        ddx <= bx - ax;
        ddy <= by - ay;
      end
      SP_ORDER: begin
        steep <= steep_c;
        if (su0 > su1) begin
          u     <= su1;
          v     <= sv1;
          u_end <= su0;
          v_end <= sv0;
        end else begin
          u     <= su0;
          v     <= sv0;
          u_end <= su1;
          v_end <= sv1;
        end
      end
      SP_PREP: begin
        dx  <= POS_W'(dx_c);
        dy  <= dv_c[POS_W-1] ? POS_W'(-dv_c) : POS_W'(dv_c);
        err <= $signed({2'b00, dx_c[POS_W-1:1]});
        up  <= v < v_end;
        cnt <= dx_c[COORD_W-1:0];
      end
      SP_WALK: begin
        u   <= u + POS_W'(1);
        cnt <= cnt - COORD_W'(1);
        if (err_dec < 0) begin
          v   <= up ? v + POS_W'(1) : v - POS_W'(1);
          err <= err_dec + $signed({1'b0, dx});
        end else begin
          err <= err_dec;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    pix.valid = (state == SP_WALK);
    pix.last  = (cnt == '0);
    pix.x     = steep ? v : u;
    pix.y     = steep ? u : v;
  end

endmodule

`default_nettype wire

// ===== hdl/page_framebuffer_line_rasterizer.sv =====
`default_nettype none

// Channel   Dir  Payload
// s_*       in   tuser: func[1:0]; tdata: start_x, start_y, end_x, end_y, pen, read_index
// m_*       out  tdata: read_data[7:0], visible_pixels[15:8]
//
// Line items walk one pixel per cycle, max(|dx|,|dy|) + 1 pixels in all, and the
// read-modify-write of the frame store keeps pace with the walk.
// Clear items sweep the store, one byte a cycle, WIDTH_PX * ceil(HEIGHT_PX / 8)
// bytes in all. Read items pass through ST_RDWAIT and ST_FINISH. After reset the
// same sweep runs (1024 bytes at default size) with s_tready low. A result waits in
// the output register for m_tready while the next item is accepted.
module page_framebuffer_line_rasterizer #(
  parameter int WIDTH_PX  = pflr_pkg::DEF_WIDTH_PX,
  parameter int HEIGHT_PX = pflr_pkg::DEF_HEIGHT_PX
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  // start_x[11:0], start_y[23:12], end_x[35:24], end_y[47:36], pen[48],
  // read_index[58:49], zero pad[63:59]
  input  wire logic [63:0] s_tdata,
  // func[1:0]
  input  wire logic [1:0]  s_tuser,
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  // read_data[7:0], visible_pixels[15:8]
  output      logic [15:0] m_tdata
);

  localparam int PAGES       = (HEIGHT_PX + 7) / 8;
  localparam int STORE_BYTES = WIDTH_PX * PAGES;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int COORD_W     = pflr_pkg::COORD_W;
  localparam int BYTE_W      = pflr_pkg::BYTE_W;
  localparam int COUNT_W     = pflr_pkg::COUNT_W;
  localparam int INDEX_W     = pflr_pkg::INDEX_W;
  localparam int SHIFT       = pflr_pkg::PAGE_SHIFT;
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_LINE   = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_RDWAIT = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state;

  // Unpack the input transfer
  logic        [pflr_pkg::FUNC_W-1:0] func;
  logic signed [COORD_W-1:0]          start_x, start_y, end_x, end_y;
  logic                               pen_in;
  logic        [INDEX_W-1:0]          read_index;
  logic                               accept;

  assign func       = s_tuser;
  assign start_x    = s_tdata[11:0];
  assign start_y    = s_tdata[23:12];
  assign end_x      = s_tdata[35:24];
  assign end_y      = s_tdata[47:36];
  assign pen_in     = s_tdata[48];
  assign read_index = s_tdata[58:49];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Line walker
  pflr_pkg::pixel_t pix;

  pflr_stepper u_stepper (
    .clk   (clk),
    .rst   (rst),
    .start (accept && (func == pflr_pkg::FUNC_LINE)),
    .ax_in (start_x),
    .ay_in (start_y),
    .bx_in (end_x),
    .by_in (end_y),
    .pix   (pix)
  );

  // Screen test and byte address of the current pixel
  logic          pix_on;
  logic [AW-1:0] pix_addr;
  logic          pix_hit;

  always_comb begin
    pix_on   = !pix.x[COORD_W] && (pix.x[COORD_W-1:0] < COORD_W'(WIDTH_PX)) &&
               !pix.y[COORD_W] && (pix.y[COORD_W-1:0] < COORD_W'(HEIGHT_PX));
    pix_addr = AW'(pix.x[COORD_W-1:0]) +
               AW'(pix.y[COORD_W-1:SHIFT]) * AW'(WIDTH_PX);
    pix_hit  = (state == ST_LINE) && pix.valid && pix_on;
  end

  // Frame store: one read port, one write port, registered read data
  logic [BYTE_W-1:0] frame_store [STORE_BYTES];
  logic [BYTE_W-1:0] rd_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [BYTE_W-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) frame_store[wr_addr] <= wr_data;
    if (rd_en) rd_data <= frame_store[rd_addr];
  end

  always_comb begin
    if (state == ST_LINE) begin
      rd_en   = pix_hit;
      rd_addr = pix_addr;
    end else begin
      rd_en   = accept && (func == pflr_pkg::FUNC_READ);
      rd_addr = AW'(read_index);
    end
  end

  // Modify stage: the byte read last cycle gets its pixel bit. The write of the
  // previous cycle landed after that read, so forward it on an address match.
  logic              s2_valid;
  logic [AW-1:0]     s2_addr;
  logic [2:0]        s2_bit;
  logic              pen;
  logic              last_valid;
  logic [AW-1:0]     last_addr;
  logic [BYTE_W-1:0] last_data;
  logic [AW-1:0]     clr_cnt;
  logic [BYTE_W-1:0] base;
  logic [BYTE_W-1:0] bit_mask;

  always_comb begin
    base     = (last_valid && (last_addr == s2_addr)) ? last_data : rd_data;
    bit_mask = BYTE_W'(1) << s2_bit;
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_data = '0;
    end else begin
      wr_en   = s2_valid;
      wr_addr = s2_addr;
      // pen high clears the bit, low sets it
      wr_data = pen ? (base & ~bit_mask) : (base | bit_mask);
    end
  end

  // Result assembly
  logic               clr_reply;
  logic               rd_in_range;
  logic [BYTE_W-1:0]  res_read;
  logic [COUNT_W-1:0] vis_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_cnt    <= '0;
      clr_reply  <= 1'b0;
      m_tvalid   <= 1'b0;
      s2_valid   <= 1'b0;
      last_valid <= 1'b0;
    end else begin
      s2_valid   <= pix_hit;
      last_valid <= wr_en;
      if (m_tvalid && m_tready && (state != ST_FINISH)) m_tvalid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          if (clr_cnt == LAST_ADDR) begin
            clr_cnt   <= '0;
            clr_reply <= 1'b0;
            state     <= clr_reply ? ST_FINISH : ST_IDLE;
          end else begin
            clr_cnt <= clr_cnt + AW'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            unique case (func)
              pflr_pkg::FUNC_CLEAR: begin
                state     <= ST_CLEAR;
                clr_reply <= 1'b1;
              end
              pflr_pkg::FUNC_LINE: state <= ST_LINE;
              pflr_pkg::FUNC_READ: state <= ST_RDWAIT;
              default:             state <= ST_FINISH;
            endcase
          end
        end
        // Hold here until the walker hands over its last pixel
        ST_LINE:   if (pix.valid && pix.last) state <= ST_DRAIN;
        // Let the final write retire
        ST_DRAIN:  state <= ST_FINISH;
        ST_RDWAIT: state <= ST_FINISH;
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    s2_addr   <= pix_addr;
    s2_bit    <= pix.y[2:0];
    last_addr <= wr_addr;
    last_data <= wr_data;
    if (accept) begin
      pen         <= pen_in;
      rd_in_range <= 32'(read_index) < 32'(STORE_BYTES);
      res_read    <= '0;
      vis_cnt     <= '0;
    end
    // Count on-screen pixels, saturating
    if (pix_hit && (vis_cnt != '1)) vis_cnt <= vis_cnt + COUNT_W'(1);
    if (state == ST_RDWAIT) res_read <= rd_in_range ? rd_data : '0;
    if ((state == ST_FINISH) && (!m_tvalid || m_tready)) m_tdata <= {vis_cnt, res_read};
  end

endmodule

`default_nettype wire
